[hw/rtl/viterbi_path_breakpoints_assert.svh]
// Assertion macros shared by the checkers of the Viterbi breakpoint decoder.
// Depends on nothing; the including file supplies clock, reset and signals.
`ifndef VITERBI_PATH_BREAKPOINTS_ASSERT_SVH
`define VITERBI_PATH_BREAKPOINTS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define VPB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/vpb_pkg.sv]
// Shared constants, types and codes of the Viterbi breakpoint decoder.
// Depends on nothing; every other file but the RAM and the assertion macros imports it.
package vpb_pkg;

    localparam int NUM_STATES = 16;
    localparam int MAX_SITES  = 64;
    localparam int SCORE_W    = 32;
    localparam int PREV_W     = 42;
    localparam int ACT_W      = 5;
    localparam int POS_W      = 31;
    localparam int OUT_W      = 32;
    localparam int DATA_W     = 32;
    localparam int PADDR_W    = 3;
    localparam int IDX_W      = $clog2(NUM_STATES);
    localparam int CNT_W      = $clog2(NUM_STATES + 1);
    localparam int SITE_W     = $clog2(MAX_SITES);
    localparam int ROW_W      = NUM_STATES * IDX_W;

    // Register index of the state count register.
    localparam logic [PADDR_W-3:0] REG_ACTIVE_STATES = '0;
    localparam logic [ACT_W-1:0]   ACT_RESET         = ACT_W'(NUM_STATES);

    // Operation applied to every cell of the ring in the same cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_STEP,
        CELL_COMMIT
    } cell_op_t;

    typedef struct packed {
        cell_op_t             op;
        logic                 first;
        logic                 plain;
        logic                 site0;
        logic                 wr;
        logic [IDX_W-1:0]     wr_idx;
    } cell_ctrl_t;

    // Source column entry that circulates around the ring.
    typedef struct packed {
        logic signed [PREV_W-1:0]  prev;
        logic signed [SCORE_W-1:0] trans;
        logic signed [SCORE_W-1:0] stay;
        logic [IDX_W-1:0]          idx;
    } token_t;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_LOAD,
        ST_ACS,
        ST_FINISH,
        ST_SEL_LOAD,
        ST_SEL,
        ST_PICK,
        ST_TB_RD,
        ST_TB_USE,
        ST_EMIT
    } ctl_state_t;

endpackage

[hw/rtl/vpb_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module vpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/vpb_cell.sv]
// One add-compare-select cell of the ring: holds one state's column entry
// and scores and compares the source entry passing by. Depends on vpb_pkg.
module vpb_cell (
    input  logic                               aclk,
    input  vpb_pkg::cell_ctrl_t                ctrl,
    input  logic [vpb_pkg::IDX_W-1:0]          cell_idx,
    input  logic                               obs,
    input  logic signed [vpb_pkg::SCORE_W-1:0] het,
    input  logic signed [vpb_pkg::SCORE_W-1:0] hom,
    input  logic signed [vpb_pkg::SCORE_W-1:0] trans_in,
    input  logic signed [vpb_pkg::SCORE_W-1:0] stay_in,
    input  vpb_pkg::token_t                    tok_in,
    output vpb_pkg::token_t                    tok_out,
    output logic [vpb_pkg::IDX_W-1:0]          arg_out
);
    import vpb_pkg::*;

    logic signed [PREV_W-1:0]  prev_reg;
    logic signed [SCORE_W-1:0] trans_reg;
    logic signed [SCORE_W-1:0] stay_reg;
    logic signed [SCORE_W-1:0] mut_reg;
    token_t                    tok_reg;
    logic signed [PREV_W-1:0]  best_reg;
    logic [IDX_W-1:0]          arg_reg;

    logic signed [SCORE_W-1:0] addend;
    logic signed [PREV_W-1:0]  addend_ext;
    logic signed [PREV_W-1:0]  mut_ext;
    logic signed [PREV_W-1:0]  cand;
    logic                      take;

    // Score of the passing source for this target; ties go to the lower source.
    always_comb begin
        if (ctrl.plain) begin
            addend = '0;
        end else if (tok_reg.idx == cell_idx) begin
            addend = tok_reg.stay;
        end else begin
            addend = tok_reg.trans;
        end
        addend_ext = {{(PREV_W-SCORE_W){addend[SCORE_W-1]}}, addend};
        mut_ext    = {{(PREV_W-SCORE_W){mut_reg[SCORE_W-1]}}, mut_reg};
        cand       = tok_reg.prev + addend_ext;
        take       = ctrl.first || (cand > best_reg) ||
                     ((cand == best_reg) && (tok_reg.idx < arg_reg));
    end

    // Item capture, token shift and column update.
    always_ff @(posedge aclk) begin
        if (ctrl.wr && (ctrl.wr_idx == cell_idx)) begin
            mut_reg   <= obs ? het : hom;
            trans_reg <= trans_in;
            stay_reg  <= stay_in;
        end
        case (ctrl.op)
            CELL_LOAD: begin
                tok_reg.prev  <= prev_reg;
                tok_reg.trans <= trans_reg;
                tok_reg.stay  <= stay_reg;
                tok_reg.idx   <= cell_idx;
            end
            CELL_STEP: begin
                tok_reg <= tok_in;
                if (take) begin
                    best_reg <= cand;
                    arg_reg  <= tok_reg.idx;
                end
            end
            CELL_COMMIT: begin
                prev_reg <= ctrl.site0 ? mut_ext : best_reg + mut_ext;
            end
            default: begin
            end
        endcase
    end

    assign tok_out = tok_reg;
    assign arg_out = arg_reg;

endmodule

[hw/rtl/viterbi_path_breakpoints.sv]
// Top level of the Viterbi breakpoint decoder: control, ring of cells and
// back-pointer memory. Depends on vpb_pkg, vpb_cell and vpb_ram.
//
//   Channel | Ports                      | Moves
//   --------+----------------------------+-----------------------------------
//   config  | psel penable pwrite paddr  | active_states write and read-back
//   input   | s_valid s_ready s_*        | one state's scores for one site
//   result  | m_valid m_ready m_*        | one breakpoint position per transfer
//
// Items are taken back to back while collecting; the item that completes a site then has
// the ring rotate the K column entries past every cell (K = active states), except on the
// first site. A final site then adds the best-state search, a back-pointer walk with a read
// and a use state per site (one memory read each) and a scan over the sites while
// emitting. Reset is synchronous and needs no clearing pass.
// Results wait in an output register; result back pressure stalls only emitting.
module viterbi_path_breakpoints (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vpb_pkg::PADDR_W-1:0]         paddr,
    input  logic [vpb_pkg::DATA_W-1:0]          pwdata,
    output logic [vpb_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_observation,
    input  logic signed [vpb_pkg::SCORE_W-1:0]  s_het_score,
    input  logic signed [vpb_pkg::SCORE_W-1:0]  s_hom_score,
    input  logic signed [vpb_pkg::SCORE_W-1:0]  s_trans_score,
    input  logic signed [vpb_pkg::SCORE_W-1:0]  s_stay_score,
    input  logic [vpb_pkg::POS_W-1:0]           s_base_position,
    input  logic                                s_last_site,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [vpb_pkg::OUT_W-1:0]           m_breakpoint_position,
    output logic                                m_last
);
    import vpb_pkg::*;

    ctl_state_t           state_reg, state_next;
    logic [ACT_W-1:0]     act_reg, act_next;
    logic [SITE_W-1:0]    site_reg, site_next;
    logic [IDX_W-1:0]     scnt_reg, scnt_next;
    logic [IDX_W-1:0]     step_reg, step_next;
    logic                 lastq_reg, lastq_next;
    logic [POS_W-1:0]     base_reg, base_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [SITE_W-1:0]    j_reg, j_next;
    logic [MAX_SITES-1:0] flags_reg, flags_next;
    logic                 mv_reg, mv_next;
    logic [OUT_W-1:0]     mpos_reg, mpos_next;
    logic                 mlast_reg, mlast_next;

    logic [CNT_W-1:0]     keff;
    logic [IDX_W-1:0]     kmax;
    logic                 cfg_wr;
    logic                 slot_free;
    logic [IDX_W-1:0]     bp_state;
    logic [MAX_SITES-1:0] flags_clr;
    logic                 ram_we;
    logic [ROW_W-1:0]     bp_row;
    logic [ROW_W-1:0]     ram_rdata;
    cell_ctrl_t           cell_ctrl;
    token_t               tok_in  [NUM_STATES];
    token_t               tok_out [NUM_STATES];
    logic [IDX_W-1:0]     arg     [NUM_STATES];

    // Effective state count: zero acts as one, large values saturate.
    always_comb begin
        if (act_reg == '0) begin
            keff = CNT_W'(1);
        end else if (int'(act_reg) > NUM_STATES) begin
            keff = CNT_W'(NUM_STATES);
        end else begin
            keff = CNT_W'(act_reg);
        end
        kmax = IDX_W'(keff - CNT_W'(1));
    end

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite &&
                    (paddr[PADDR_W-1:2] == REG_ACTIVE_STATES);
    assign prdata = (paddr[PADDR_W-1:2] == REG_ACTIVE_STATES) ?
                    DATA_W'(act_reg) : '0;

    // Ring of cells; the entry after the last active cell wraps to cell zero.
    for (genvar c = 0; c < NUM_STATES; c++) begin : g_cell
        vpb_cell u_cell (
            .aclk     (aclk),
            .ctrl     (cell_ctrl),
            .cell_idx (IDX_W'(c)),
            .obs      (s_observation),
            .het      (s_het_score),
            .hom      (s_hom_score),
            .trans_in (s_trans_score),
            .stay_in  (s_stay_score),
            .tok_in   (tok_in[c]),
            .tok_out  (tok_out[c]),
            .arg_out  (arg[c])
        );
        if (c == NUM_STATES - 1) begin : g_wrap
            assign tok_in[c] = tok_out[0];
        end else begin : g_link
            assign tok_in[c] = (keff == CNT_W'(c + 1)) ? tok_out[0] : tok_out[c + 1];
        end
        assign bp_row[c*IDX_W +: IDX_W] = arg[c];
    end

    // Back-pointer rows, one per site.
    vpb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SITES)
    ) u_bp_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (site_reg),
        .wdata (bp_row),
        .raddr (j_reg),
        .rdata (ram_rdata)
    );

    assign slot_free = !mv_reg || m_ready;
    assign bp_state  = ram_rdata[cur_reg*IDX_W +: IDX_W];
    assign flags_clr = flags_reg & ~(MAX_SITES'(1) << j_reg);
    assign s_ready   = (state_reg == ST_COLLECT);

    // Next state and outputs of the sequencer.
    always_comb begin
        state_next = state_reg;
        act_next   = act_reg;
        site_next  = site_reg;
        scnt_next  = scnt_reg;
        step_next  = step_reg;
        lastq_next = lastq_reg;
        base_next  = base_reg;
        cur_next   = cur_reg;
        j_next     = j_reg;
        flags_next = flags_reg;
        mv_next    = mv_reg && !m_ready;
        mpos_next  = mpos_reg;
        mlast_next = mlast_reg;
        ram_we     = 1'b0;
        cell_ctrl.op     = CELL_HOLD;
        cell_ctrl.first  = (step_reg == '0);
        cell_ctrl.plain  = 1'b0;
        cell_ctrl.site0  = (site_reg == '0);
        cell_ctrl.wr     = 1'b0;
        cell_ctrl.wr_idx = scnt_reg;

        unique case (state_reg)
            ST_COLLECT: begin
                if (s_valid) begin
                    cell_ctrl.wr = 1'b1;
                    if ((site_reg == '0) && (scnt_reg == '0)) begin
                        base_next = s_base_position;
                    end
                    if (scnt_reg == kmax) begin
                        scnt_next  = '0;
                        lastq_next = s_last_site || (site_reg == SITE_W'(MAX_SITES - 1));
                        state_next = (site_reg == '0) ? ST_FINISH : ST_LOAD;
                    end else begin
                        scnt_next = scnt_reg + 1'b1;
                    end
                end
            end
            ST_LOAD: begin
                cell_ctrl.op = CELL_LOAD;
                step_next    = '0;
                state_next   = ST_ACS;
            end
            ST_ACS: begin
                cell_ctrl.op = CELL_STEP;
                if (step_reg == kmax) begin
                    state_next = ST_FINISH;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                cell_ctrl.op = CELL_COMMIT;
                ram_we       = (site_reg != '0);
                if (lastq_reg) begin
                    state_next = ST_SEL_LOAD;
                end else begin
                    site_next  = site_reg + 1'b1;
                    state_next = ST_COLLECT;
                end
            end
            ST_SEL_LOAD: begin
                cell_ctrl.op = CELL_LOAD;
                step_next    = '0;
                state_next   = ST_SEL;
            end
            ST_SEL: begin
                cell_ctrl.op    = CELL_STEP;
                cell_ctrl.plain = 1'b1;
                if (step_reg == kmax) begin
                    state_next = ST_PICK;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_PICK: begin
                // Cell zero now holds the best final state.
                cur_next   = arg[0];
                flags_next = MAX_SITES'(1);
                if (site_reg == '0) begin
                    j_next     = '0;
                    state_next = ST_EMIT;
                end else begin
                    j_next     = site_reg;
                    state_next = ST_TB_RD;
                end
            end
            ST_TB_RD: begin
                state_next = ST_TB_USE;
            end
            ST_TB_USE: begin
                flags_next[j_reg] = (bp_state != cur_reg);
                cur_next          = bp_state;
                if (j_reg == SITE_W'(1)) begin
                    j_next     = '0;
                    state_next = ST_EMIT;
                end else begin
                    j_next     = j_reg - 1'b1;
                    state_next = ST_TB_RD;
                end
            end
            ST_EMIT: begin
                if (flags_reg[j_reg]) begin
                    if (slot_free) begin
                        flags_next = flags_clr;
                        mv_next    = 1'b1;
                        mpos_next  = OUT_W'(base_reg) + OUT_W'(j_reg);
                        mlast_next = (flags_clr == '0);
                        if (flags_clr == '0) begin
                            site_next  = '0;
                            state_next = ST_COLLECT;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_COLLECT;
            end
        endcase

        // A write of the state count aborts any run in progress.
        if (cfg_wr) begin
            act_next   = pwdata[ACT_W-1:0];
            site_next  = '0;
            scnt_next  = '0;
            state_next = ST_COLLECT;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
            act_reg   <= ACT_RESET;
            site_reg  <= '0;
            scnt_reg  <= '0;
            base_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            act_reg   <= act_next;
            site_reg  <= site_next;
            scnt_reg  <= scnt_next;
            base_reg  <= base_next;
            mv_reg    <= mv_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        step_reg  <= step_next;
        lastq_reg <= lastq_next;
        cur_reg   <= cur_next;
        j_reg     <= j_next;
        flags_reg <= flags_next;
        mpos_reg  <= mpos_next;
        mlast_reg <= mlast_next;
    end

    assign m_valid               = mv_reg;
    assign m_breakpoint_position = mpos_reg;
    assign m_last                = mlast_reg;

endmodule

[hw/rtl/vpb_checker.sv]
// Port-level checker of the Viterbi breakpoint decoder, bound to the top level.
// Depends on vpb_pkg and viterbi_path_breakpoints_assert.svh.
`include "viterbi_path_breakpoints_assert.svh"

module vpb_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [vpb_pkg::PADDR_W-1:0]         paddr,
    input logic [vpb_pkg::DATA_W-1:0]          pwdata,
    input logic [vpb_pkg::DATA_W-1:0]          prdata,
    input logic                                pready,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [vpb_pkg::OUT_W-1:0]           m_breakpoint_position,
    input logic                                m_last
);
    import vpb_pkg::*;

    // The configuration port never inserts wait states.
    `VPB_ASSERT_SAME(a_pready_high, aclk, aresetn, 1'b1, pready, "pready low")

    // A stalled result holds its value.
    `VPB_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_breakpoint_position) && $stable(m_last), "stalled result changed")

    // While items are taken, only the final result of a run may still wait.
    `VPB_ASSERT_SAME(a_input_after_run, aclk, aresetn, s_valid && s_ready && m_valid, m_last, "input taken while a run is still emitting")

    // A state count write reads back in the next cycle.
    `VPB_ASSERT_NEXT(a_cfg_readback, aclk, aresetn, psel && penable && pwrite && !paddr[2], prdata[ACT_W-1:0] == $past(pwdata[ACT_W-1:0]), "state count read-back mismatch")

endmodule

bind viterbi_path_breakpoints vpb_checker u_vpb_checker (.*);

[sim/viterbi_path_breakpoints_checker.sv]
// Checker for the Viterbi breakpoint decoder: watches the config, input and result channels,
// predicts breakpoint positions and compares every result transfer. Depends on vpb_pkg.
module viterbi_path_breakpoints_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [vpb_pkg::PADDR_W-1:0]         paddr,
    input  logic [vpb_pkg::DATA_W-1:0]          pwdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic                                s_observation,
    input  logic signed [vpb_pkg::SCORE_W-1:0]  s_het_score,
    input  logic signed [vpb_pkg::SCORE_W-1:0]  s_hom_score,
    input  logic signed [vpb_pkg::SCORE_W-1:0]  s_trans_score,
    input  logic signed [vpb_pkg::SCORE_W-1:0]  s_stay_score,
    input  logic [vpb_pkg::POS_W-1:0]           s_base_position,
    input  logic                                s_last_site,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [vpb_pkg::OUT_W-1:0]           m_breakpoint_position,
    input  logic                                m_last,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import vpb_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] pos;
        logic             last;
    } breakpoint_t;

    // Predicted decoder state.
    logic [ACT_W-1:0]          state_count;
    logic signed [PREV_W-1:0]  path_score [NUM_STATES];
    logic signed [PREV_W-1:0]  mut_col    [NUM_STATES];
    logic signed [PREV_W-1:0]  trans_col  [NUM_STATES];
    logic signed [PREV_W-1:0]  stay_col   [NUM_STATES];
    logic [IDX_W-1:0]          survivor   [MAX_SITES][NUM_STATES];
    int                        site_idx;
    int                        state_idx;
    logic [POS_W-1:0]          run_base;
    breakpoint_t               expected_bps[$];

    assign pending = expected_bps.size();

    function automatic int states_in_use();
        if (state_count == 0) return 1;
        if (state_count > NUM_STATES) return NUM_STATES;
        return int'(state_count);
    endfunction

    // Consume one accepted item and queue any breakpoints it completes.
    task automatic decode_item();
        int kn, st, si, n, best_k;
        logic signed [PREV_W-1:0] best, sc;
        logic signed [PREV_W-1:0] col [NUM_STATES];
        logic [IDX_W-1:0] path [MAX_SITES];
        breakpoint_t bp;
        kn = states_in_use();
        st = (state_idx >= kn) ? kn - 1 : state_idx;
        si = (site_idx >= MAX_SITES) ? MAX_SITES - 1 : site_idx;
        mut_col[st]   = s_observation ? PREV_W'(s_het_score) : PREV_W'(s_hom_score);
        trans_col[st] = PREV_W'(s_trans_score);
        stay_col[st]  = PREV_W'(s_stay_score);
        if (si == 0 && st == 0) run_base = s_base_position;
        if (st + 1 < kn) begin
            state_idx = st + 1;
            return;
        end
        state_idx = 0;
        if (si == 0) begin
            for (int i = 0; i < kn; i++) path_score[i] = mut_col[i];
        end else begin
            for (int i = 0; i < kn; i++) begin
                best = 0;
                best_k = 0;
                for (int k = 0; k < kn; k++) begin
                    sc = path_score[k] + ((k == i) ? stay_col[k] : trans_col[k]);
                    if (k == 0 || sc > best) begin
                        best = sc;
                        best_k = k;
                    end
                end
                col[i] = best + mut_col[i];
                survivor[si][i] = IDX_W'(best_k);
            end
            for (int i = 0; i < kn; i++) path_score[i] = col[i];
        end
        if (!s_last_site && si + 1 < MAX_SITES) begin
            site_idx = si + 1;
            return;
        end
        site_idx = 0;
        // Trace back from the best final state, ties to the lowest state.
        n = si + 1;
        best = path_score[0];
        best_k = 0;
        for (int k = 1; k < kn; k++) begin
            if (path_score[k] > best) begin
                best = path_score[k];
                best_k = k;
            end
        end
        path[n-1] = IDX_W'(best_k);
        for (int j = n - 1; j >= 1; j--) path[j-1] = survivor[j][path[j]];
        bp.pos = OUT_W'(run_base);
        bp.last = 1'b0;
        expected_bps = {expected_bps, bp};
        for (int j = 1; j < n; j++) begin
            if (path[j-1] != path[j]) begin
                bp.pos = OUT_W'(run_base) + OUT_W'(j);
                expected_bps = {expected_bps, bp};
            end
        end
        expected_bps[$].last = 1'b1;
    endtask

    // Track transfers on every channel.
    always @(posedge aclk) begin
        breakpoint_t exp_bp;
        if (!aresetn) begin
            state_count = ACT_RESET;
            site_idx = 0;
            state_idx = 0;
            run_base = '0;
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[PADDR_W-1:2] == REG_ACTIVE_STATES) begin
                state_count = pwdata[ACT_W-1:0];
                site_idx = 0;
                state_idx = 0;
            end
            if (s_valid && s_ready) decode_item();
            if (m_valid && m_ready) begin
                if (expected_bps.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected breakpoint %0d last=%0b",
                                 m_breakpoint_position, m_last);
                end else begin
                    exp_bp = expected_bps.pop_front();
                    if (exp_bp.pos !== m_breakpoint_position || exp_bp.last !== m_last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("ERROR: breakpoint expected %0d last=%0b, got %0d last=%0b",
                                     exp_bp.pos, exp_bp.last, m_breakpoint_position, m_last);
                    end
                end
            end
        end
    end
endmodule

[sim/viterbi_path_breakpoints_tb.sv]
// Testbench top for the Viterbi breakpoint decoder: drives runs of sites and register writes.
// Depends on vpb_pkg, viterbi_path_breakpoints and viterbi_path_breakpoints_checker.
module viterbi_path_breakpoints_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vpb_pkg::*;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]         pwdata = '0;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic                      s_observation = 1'b0;
    logic signed [SCORE_W-1:0] s_het_score = '0;
    logic signed [SCORE_W-1:0] s_hom_score = '0;
    logic signed [SCORE_W-1:0] s_trans_score = '0;
    logic signed [SCORE_W-1:0] s_stay_score = '0;
    logic [POS_W-1:0]          s_base_position = '0;
    logic                      s_last_site = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [OUT_W-1:0]          m_breakpoint_position;
    logic                      m_last;
    int                        fail_count;
    int                        pending;
    int                        items_sent;
    bit                        stim_done = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    viterbi_path_breakpoints i_dut (.*);

    viterbi_path_breakpoints_checker i_checker (.*);

    // Result side holds ready low for a random gap, at times none, before each transfer.
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
        end
    end

    task automatic write_active_states(input int value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {REG_ACTIVE_STATES, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Release the input and wait for the block to drain before a register write.
    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic logic signed [SCORE_W-1:0] pick_score(input int mode);
        case (mode)
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return SCORE_W'($urandom_range(0, 4)) - 2;
            default: return $urandom;
        endcase
    endfunction

    // One transfer on the input channel, with a random lead-in gap when allowed; valid stays
    // high after the transfer until the next gap or the next drain.
    task automatic send_item(input int mode, input logic last_site, input bit allow_gap);
        int gap;
        gap = (allow_gap && $urandom_range(0, 2) != 0) ? $urandom_range(0, 18) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_observation   <= 1'($urandom_range(0, 1));
        s_het_score     <= pick_score(mode);
        s_hom_score     <= pick_score(mode);
        s_trans_score   <= pick_score(mode);
        s_stay_score    <= pick_score(mode);
        s_base_position <= (mode < 2) ? POS_W'(mode ? 0 : 31'h7FFFFFFF) : POS_W'($urandom);
        s_last_site     <= last_site;
        @(posedge aclk iff s_ready);
        items_sent++;
    endtask

    task automatic send_run(input int kn, input int sites, input int mode);
        for (int si = 0; si < sites; si++)
            for (int st = 0; st < kn; st++)
                send_item((mode < 0) ? $urandom_range(0, 3) : mode,
                          si == sites - 1, 1'b1);
    endtask

    initial begin
        int kn;
        items_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: single states with extreme scores, then a single-site run.
        write_active_states(1);
        send_run(1, 3, 0);
        send_run(1, 2, 1);
        drain();
        write_active_states(0);
        send_run(1, 1, 3);
        drain();
        // Aborted run: a register write drops a partial site.
        write_active_states(3);
        send_item(3, 1'b0, 1'b0);
        drain();
        write_active_states(2);
        send_run(2, 4, 2);
        drain();
        // Values above the state count saturate to the largest count.
        write_active_states(31);
        send_run(16, 1, 3);
        drain();
        // A run longer than the site limit ends by itself.
        write_active_states(1);
        send_run(1, MAX_SITES + 2, 2);
        drain();
        // Random runs with small tie-prone scores and wide values mixed.
        while (items_sent < 165) begin
            kn = ($urandom_range(0, 7) == 0) ? NUM_STATES : $urandom_range(1, 4);
            write_active_states(kn);
            for (int r = 0; r < ((kn == NUM_STATES) ? 1 : 3); r++)
                send_run(kn, $urandom_range(1, (kn == NUM_STATES) ? 2 : 6), -1);
            drain();
        end
        stim_done = 1'b1;
    end

    initial begin
        @(posedge aclk iff stim_done);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #3ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
